// File: rtl/olpfdm_pkg.sv
// package for the ordered list with push-front insert and delete of first match
// holds the beat types, status and operation codes, and the cell control struct
// no dependencies
package olpfdm_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  localparam int unsigned CountW = 5;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    status_e           status;
    logic [CountW-1:0] entry_count;
  } out_beat_t;

  typedef struct packed {
    logic shift_back;
    logic shift_fwd;
  } cell_ctrl_t;

endpackage

// File: rtl/olpfdm_cell.sv
// one list cell: holds one entry, compares it with the search key
// and loads from its front or back neighbor; uses olpfdm_pkg
module olpfdm_cell (
  input  logic                     clk_i,
  input  olpfdm_pkg::cell_ctrl_t   ctrl_i,
  input  logic                     occupied_i,
  input  logic signed [31:0]       key_i,
  input  logic signed [31:0]       front_i,
  input  logic signed [31:0]       back_i,
  output logic signed [31:0]       value_o,
  output logic                     match_o
);
  import olpfdm_pkg::*;

  logic signed [31:0] value_q;
  logic signed [31:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift_back) begin
      value_d = front_i;
    end else if (ctrl_i.shift_fwd) begin
      value_d = back_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = occupied_i && (value_q == key_i);

endmodule

// File: rtl/ordered_list_push_front_delete_match.sv
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells, front
// first. An insert beat pushes its value at the front, every held entry moving back
// one cell; a delete beat removes the entry nearest the front that equals its value,
// the cells behind it pulling forward. All cells compare at once and a match flag
// runs down the row, so one beat is taken every cycle while the output is not stalled;
// its result appears in the output register in the next cycle. Each beat yields one
// result: status and the entry count afterwards. Uses olpfdm_pkg and olpfdm_cell.
module ordered_list_push_front_delete_match #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  olpfdm_pkg::in_beat_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output olpfdm_pkg::out_beat_t out_data_o
);
  import olpfdm_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic               out_valid_q;
  logic               out_valid_d;
  out_beat_t          out_data_q;
  out_beat_t          out_data_d;

  logic               accept;
  logic               full;
  logic               found;
  logic               do_ins;
  logic               do_del;
  logic [CntW+CountW-1:0] count_ext;

  logic signed [31:0] cell_val [DEPTH];
  logic [DEPTH-1:0]   cell_match;
  logic [DEPTH-1:0]   cell_occ;
  logic [DEPTH:0]     hit_chain;
  cell_ctrl_t         cell_ctrl [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign found      = hit_chain[DEPTH];
  assign do_ins     = accept && (in_data_i.operation == OP_INSERT) && !full;
  assign do_del     = accept && (in_data_i.operation == OP_DELETE) && found;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] front_val;
    logic signed [31:0] back_val;

    assign cell_occ[i]     = (CntW'(i) < count_q);
    assign hit_chain[i+1]  = hit_chain[i] | cell_match[i];
    assign cell_ctrl[i].shift_back = do_ins;
    assign cell_ctrl[i].shift_fwd  = do_del && hit_chain[i+1];

    if (i == 0) begin : g_front
      assign front_val = in_data_i.value;
    end else begin : g_mid
      assign front_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign back_val = cell_val[i];
    end else begin : g_inner
      assign back_val = cell_val[i+1];
    end

    olpfdm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[i]),
      .occupied_i (cell_occ[i]),
      .key_i      (in_data_i.value),
      .front_i    (front_val),
      .back_i     (back_val),
      .value_o    (cell_val[i]),
      .match_o    (cell_match[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + 1'b1;
    end else if (do_del) begin
      count_d = count_q - 1'b1;
    end
  end

  assign count_ext = {{CountW{1'b0}}, count_d};

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d            = 1'b1;
      out_data_d.entry_count = count_ext[CountW-1:0];
      if (in_data_i.operation == OP_INSERT) begin
        out_data_d.status = full ? ST_FULL : ST_INSERTED;
      end else begin
        out_data_d.status = found ? ST_DELETED : ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sim/ordered_list_push_front_delete_match_tb.sv
// testbench for ordered_list_push_front_delete_match: drives insert and delete beats,
// predicts status and entry count with a scoreboard class holding its own copy of the list
// depends on olpfdm_pkg and the rtl of the block
module ordered_list_push_front_delete_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import olpfdm_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_PRINTED = 50;

  class list_scoreboard;
    logic signed [31:0] held[$];
    out_beat_t expected_q[$];
    int unsigned depth;
    int unsigned errors;
    int unsigned results_seen;

    function new(int unsigned d);
      depth = d;
      errors = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic signed [31:0] pick_held();
      return held[$urandom_range(held.size() - 1)];
    endfunction

    function void note_input(in_beat_t beat);
      out_beat_t want;
      int hit;
      hit = -1;
      if (beat.operation == OP_INSERT) begin
        if (held.size() >= depth) begin
          want.status = ST_FULL;
        end else begin
          held.push_front(beat.value);
          want.status = ST_INSERTED;
        end
      end else begin
        foreach (held[i]) begin
          if (hit < 0 && held[i] === beat.value) hit = i;
        end
        if (hit >= 0) begin
          held.delete(hit);
          want.status = ST_DELETED;
        end else begin
          want.status = ST_NOT_FOUND;
        end
      end
      want.entry_count = 5'(held.size());
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d arrived with nothing expected", results_seen));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("result beat %0d status %0d, expected %0d",
                                  results_seen, got.status, want.status));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("result beat %0d entry_count %0d, expected %0d",
                                  results_seen, got.entry_count, want.entry_count));
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;

  bit calm = 1'b0;
  int unsigned idle_cycles;
  list_scoreboard sb = new(LIST_DEPTH);

  ordered_list_push_front_delete_match #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] pool_value();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return 32'($urandom_range(7));
    endcase
  endfunction

  task automatic send_beat(input op_e op, input logic signed [31:0] v);
    in_beat_t beat;
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 24) gap++;
    beat.operation = op;
    beat.value = v;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(beat);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (!hold_done && sb.results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= (!calm && $urandom_range(99) < 24);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned insert_pct;
    op_e op;
    logic signed [31:0] v;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty and one-entry cases
    send_beat(OP_DELETE, 32'sd5);
    send_beat(OP_INSERT, -32'sd1);
    send_beat(OP_DELETE, 32'sd5);
    send_beat(OP_DELETE, -32'sd1);
    // fill with extremes and a duplicate, then overflow, then delete present and absent values
    send_beat(OP_INSERT, 32'sh8000_0000);
    send_beat(OP_INSERT, 32'sh7fff_ffff);
    send_beat(OP_INSERT, 32'sh0);
    send_beat(OP_INSERT, 32'sh8000_0000);
    for (int k = 0; k < 12; k++) send_beat(OP_INSERT, 32'(100 + k));
    send_beat(OP_INSERT, 32'sd7);
    send_beat(OP_DELETE, 32'sh8000_0000);
    send_beat(OP_DELETE, 32'sh7fff_ffff);
    send_beat(OP_DELETE, 32'sd12345);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(60, 10);
      case ($urandom_range(2))
        0: insert_pct = 25;
        1: insert_pct = 50;
        default: insert_pct = 80;
      endcase
      repeat (burst_len) begin
        if (sent == 700) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        calm = (sent >= 1000 && sent < 1300);
        if ($urandom_range(99) < insert_pct) begin
          op = OP_INSERT;
          v = ($urandom_range(99) < 40) ? pool_value() : 32'($urandom);
        end else begin
          op = OP_DELETE;
          if (sb.held.size() != 0 && $urandom_range(99) < 60) v = sb.pick_held();
          else if ($urandom_range(1) == 0) v = pool_value();
          else v = 32'($urandom);
        end
        send_beat(op, v);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: ordered_list_push_front_delete_match.f
rtl/olpfdm_pkg.sv
rtl/olpfdm_cell.sv
rtl/ordered_list_push_front_delete_match.sv
sim/ordered_list_push_front_delete_match_tb.sv
